FILE: rtl/mrws_pkg.sv
package mrws_pkg;

    localparam logic [2:0] OPC_JOIN       = 3'd0;
    localparam logic [2:0] OPC_JOIN_RESP  = 3'd1;
    localparam logic [2:0] OPC_DATA       = 3'd2;
    localparam logic [2:0] OPC_KEEPALIVE  = 3'd3;
    localparam logic [2:0] OPC_FLUSH      = 3'd4;
    localparam logic [2:0] OPC_LEAVE_REQ  = 3'd5;
    localparam logic [2:0] OPC_LEAVE_RESP = 3'd6;

    localparam logic [2:0] KIND_DELIVER     = 3'd0;
    localparam logic [2:0] KIND_JOIN_REQ    = 3'd1;
    localparam logic [2:0] KIND_JOIN_ECHO   = 3'd2;
    localparam logic [2:0] KIND_UPDATE      = 3'd3;
    localparam logic [2:0] KIND_LEAVE_REQ   = 3'd4;
    localparam logic [2:0] KIND_LEFT        = 3'd5;
    localparam logic [2:0] KIND_JOIN_FAILED = 3'd6;

    localparam int BYTE_ROUND = 7;
    localparam int MAX_BYTES  = 4;
    localparam int BM_W       = 32;

    typedef enum logic [2:0] {
        CMD_JOIN,
        CMD_JOIN_RESP,
        CMD_DATA,
        CMD_KEEPALIVE,
        CMD_FLUSH,
        CMD_LEAVE_REQ,
        CMD_LEAVE_RESP
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t     op;
        logic [15:0] seq;
        logic [15:0] max_seq;
        logic [31:0] tick;
        logic [31:0] response_id;
        logic [15:0] payload_tag;
        logic        wants_update;
        logic        consumer_ready;
        logic        retries_zero;
    } cmd_t;

    typedef struct packed {
        logic [2:0]      kind;
        logic [15:0]     seq;
        logic [15:0]     max_seq;
        logic [BM_W-1:0] bitmap;
        logic [2:0]      bytes;
        logic [31:0]     tick;
        logic [15:0]     tag;
        logic            last;
    } result_t;

    function automatic result_t simple_result(input logic [2:0] kind, input logic [15:0] seq);
        result_t r;
        r = '0;
        r.kind = kind;
        r.seq = seq;
        r.last = 1'b1;
        return r;
    endfunction

endpackage

FILE: rtl/multicast_receive_window_sack.sv
// Receiver side of a reliable multicast session with a sliding reorder window.
// Commands enter on start while busy is low; each one is one transfer. A two-entry
// queue sits between the decoder and the execution engine, so busy rises only when
// both entries are taken. Results leave on out_valid for exactly one cycle each, and
// last marks the final result of a command; results cannot be held off.
// The client identifier is written on the cfg_valid/cfg_ready channel, which is
// always ready, and should be written only while no command is in flight.
// Flow: a command passes through a queue entry to the engine, which registers every
// result. Join, leave and ignored commands end in the idle state; data in the window
// goes through a prepare state to the flush state, which keepalive and tick flush
// enter directly; the flush state delivers in order, and an update pass may follow.
// The update pass is a four-stage walk over the rotated presence vector, and
// deliveries drain at one per cycle through the registered read of the tag store.
// Reset puts the link in the idle state, empties the window, clears the expected
// sequence and the client identifier. The tag store needs no clearing.
module multicast_receive_window_sack
#(
    parameter int WINDOW = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  opcode,
    input  logic [15:0] seq,
    input  logic [15:0] max_seq,
    input  logic [31:0] tick,
    input  logic [31:0] response_id,
    input  logic [15:0] payload_tag,
    input  logic        wants_update,
    input  logic        consumer_ready,
    input  logic [7:0]  retries_left,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data,
    output logic        out_valid,
    output logic [2:0]  kind,
    output logic [15:0] out_seq,
    output logic [15:0] out_max_seq,
    output logic [31:0] ack_bitmap,
    output logic [2:0]  ack_bytes,
    output logic [31:0] out_tick,
    output logic [15:0] out_tag,
    output logic        last
);

    logic              f_push;
    mrws_pkg::cmd_t    f_cmd;
    logic              q_full;
    logic              q_valid;
    logic              q_pop;
    mrws_pkg::cmd_t    q_cmd;
    logic              res_valid;
    mrws_pkg::result_t res;
    logic [31:0]       client_id_reg;

    assign cfg_ready = 1'b1;
    assign busy = q_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            client_id_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            client_id_reg <= cfg_data;
        end
    end

    mrws_front u_front
    (
        .start          (start),
        .busy           (q_full),
        .opcode         (opcode),
        .seq            (seq),
        .max_seq        (max_seq),
        .tick           (tick),
        .response_id    (response_id),
        .payload_tag    (payload_tag),
        .wants_update   (wants_update),
        .consumer_ready (consumer_ready),
        .retries_left   (retries_left),
        .push           (f_push),
        .cmd            (f_cmd)
    );

    mrws_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (f_push),
        .push_cmd (f_cmd),
        .pop      (q_pop),
        .full     (q_full),
        .valid    (q_valid),
        .head_cmd (q_cmd)
    );

    mrws_back #(
        .WINDOW (WINDOW)
    ) u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .client_id (client_id_reg),
        .q_valid   (q_valid),
        .q_cmd     (q_cmd),
        .q_pop     (q_pop),
        .res_valid (res_valid),
        .res       (res)
    );

    assign out_valid = res_valid;
    assign kind = res.kind;
    assign out_seq = res.seq;
    assign out_max_seq = res.max_seq;
    assign ack_bitmap = res.bitmap;
    assign ack_bytes = res.bytes;
    assign out_tick = res.tick;
    assign out_tag = res.tag;
    assign last = res.last;

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_full |-> !f_push)
        else $error("Command pushed into a full queue.");

    a_update_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (kind == mrws_pkg::KIND_UPDATE)) |-> last)
        else $error("Update was not the final result of its command.");

    a_update_bytes: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (kind == mrws_pkg::KIND_UPDATE))
            |-> (ack_bytes <= 3'(mrws_pkg::MAX_BYTES)))
        else $error("Bitmap byte count out of range.");

    a_bitmap_only_in_update: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (kind != mrws_pkg::KIND_UPDATE)) |-> (ack_bitmap == '0))
        else $error("Bitmap set on a result that is not an update.");

endmodule

FILE: rtl/mrws_front.sv
module mrws_front
(
    input  logic                 start,
    input  logic                 busy,
    input  logic [2:0]           opcode,
    input  logic [15:0]          seq,
    input  logic [15:0]          max_seq,
    input  logic [31:0]          tick,
    input  logic [31:0]          response_id,
    input  logic [15:0]          payload_tag,
    input  logic                 wants_update,
    input  logic                 consumer_ready,
    input  logic [7:0]           retries_left,
    output logic                 push,
    output mrws_pkg::cmd_t       cmd
);

    logic              known;
    mrws_pkg::cmd_op_t op;

    always_comb
    begin
        known = 1'b1;
        op = mrws_pkg::CMD_JOIN;
        unique case (opcode)
            mrws_pkg::OPC_JOIN:       op = mrws_pkg::CMD_JOIN;
            mrws_pkg::OPC_JOIN_RESP:  op = mrws_pkg::CMD_JOIN_RESP;
            mrws_pkg::OPC_DATA:       op = mrws_pkg::CMD_DATA;
            mrws_pkg::OPC_KEEPALIVE:  op = mrws_pkg::CMD_KEEPALIVE;
            mrws_pkg::OPC_FLUSH:      op = mrws_pkg::CMD_FLUSH;
            mrws_pkg::OPC_LEAVE_REQ:  op = mrws_pkg::CMD_LEAVE_REQ;
            mrws_pkg::OPC_LEAVE_RESP: op = mrws_pkg::CMD_LEAVE_RESP;
            default:                  known = 1'b0;
        endcase
    end

    always_comb
    begin
        cmd.op = op;
        cmd.seq = seq;
        cmd.max_seq = max_seq;
        cmd.tick = tick;
        cmd.response_id = response_id;
        cmd.payload_tag = payload_tag;
        cmd.wants_update = wants_update;
        cmd.consumer_ready = consumer_ready;
        cmd.retries_zero = (retries_left == 8'd0);
    end

    // An unused opcode is taken in as a transfer and dropped here.
    assign push = start && !busy && known;

endmodule

FILE: rtl/mrws_queue.sv
module mrws_queue
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  mrws_pkg::cmd_t push_cmd,
    input  logic           pop,
    output logic           full,
    output logic           valid,
    output mrws_pkg::cmd_t head_cmd
);

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    mrws_pkg::cmd_t   entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign full = (count_reg == CNT_W'(DEPTH));
    assign valid = (count_reg != '0);
    assign head_cmd = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (pop)
            begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

endmodule

FILE: rtl/mrws_back.sv
module mrws_back
#(
    parameter int WINDOW = 32
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [31:0]       client_id,
    input  logic              q_valid,
    input  mrws_pkg::cmd_t    q_cmd,
    output logic              q_pop,
    output logic              res_valid,
    output mrws_pkg::result_t res
);

    localparam int IDX_W = $clog2(WINDOW);
    localparam int CNT_W = $clog2(WINDOW + 1);
    localparam int SUM_W = CNT_W + 3;
    localparam int EXT_W = (WINDOW > mrws_pkg::BM_W) ? WINDOW : mrws_pkg::BM_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_FLUSH,
        ST_SCAN,
        ST_RUN,
        ST_MASK,
        ST_REPORT
    } state_t;

    typedef enum logic [1:0] {
        LINK_IDLE,
        LINK_JOIN,
        LINK_DATA,
        LINK_LEAVE
    } link_t;

    state_t            state_reg;
    link_t             link_reg;
    logic [15:0]       exp_reg;
    logic [IDX_W-1:0]  head_reg;
    logic [WINDOW-1:0] present_reg;
    mrws_pkg::cmd_t    cmd_reg;
    logic              moved_reg;
    logic [WINDOW-1:0] rot_reg;
    logic [WINDOW-1:0] neg_reg;
    logic [WINDOW-1:0] run_reg;
    logic [CNT_W-1:0]  off_reg;
    logic [WINDOW-1:0] held_reg;
    logic              any_allowed_reg;
    logic              res_valid_reg;
    mrws_pkg::result_t res_reg;

    logic [15:0]       tag_mem [WINDOW];
    logic [15:0]       tag_rd_reg;

    logic [15:0]         diff;
    logic                in_win;
    logic [IDX_W:0]      widx;
    logic [IDX_W-1:0]    slot;
    logic [IDX_W-1:0]    head_inc;
    logic                deliver;
    logic [IDX_W-1:0]    rd_addr;
    logic                follows;
    logic                upd_at_end;
    logic                store;
    logic [2*WINDOW-1:0] dbl_rot;
    logic [WINDOW-1:0]   rot;
    logic [15:0]         ref_max;
    logic [15:0]         dm;
    logic [15:0]         lane_sum [WINDOW];
    logic [WINDOW-1:0]   neg;
    logic [WINDOW:0]     rot_inc;
    logic [WINDOW-1:0]   run;
    logic [WINDOW-1:0]   first_zero;
    logic [CNT_W-1:0]    fz_idx;
    logic [CNT_W-1:0]    off;
    logic [WINDOW-1:0]   after;
    logic [WINDOW-1:0]   brk;
    logic [WINDOW-1:0]   below;
    logic [WINDOW-1:0]   allowed;
    logic [EXT_W-1:0]    held_ext;
    logic [IDX_W-1:0]    top_idx;
    logic                has_held;
    logic                one_ahead;
    logic [CNT_W-1:0]    hi_rel;
    logic [CNT_W-1:0]    span;
    logic [SUM_W-1:0]    bsum;
    logic [SUM_W-1:0]    bq;
    mrws_pkg::result_t   upd;
    mrws_pkg::result_t   dlv;

    assign q_pop = (state_reg == ST_IDLE) && q_valid;
    assign res_valid = res_valid_reg;
    assign res = res_reg;

    // Placement of a data item in the ring.
    always_comb
    begin
        diff = q_cmd.seq - exp_reg;
        in_win = (diff < 16'(WINDOW));
        widx = (IDX_W + 1)'(diff[IDX_W-1:0]) + (IDX_W + 1)'(head_reg);
        slot = (widx >= (IDX_W + 1)'(WINDOW)) ? IDX_W'(widx - (IDX_W + 1)'(WINDOW))
                                              : widx[IDX_W-1:0];
        store = q_pop && (q_cmd.op == mrws_pkg::CMD_DATA) && (link_reg == LINK_DATA) && in_win;
    end

    always_comb
    begin
        head_inc = (head_reg == IDX_W'(WINDOW - 1)) ? '0 : head_reg + IDX_W'(1);
        deliver = (state_reg == ST_FLUSH) && cmd_reg.consumer_ready && present_reg[head_reg];
        rd_addr = deliver ? head_inc : head_reg;
        unique case (cmd_reg.op)
            mrws_pkg::CMD_DATA:      follows = cmd_reg.wants_update;
            mrws_pkg::CMD_KEEPALIVE: follows = 1'b1;
            mrws_pkg::CMD_FLUSH:     follows = (link_reg == LINK_DATA);
            default:                 follows = 1'b0;
        endcase
        upd_at_end = follows && ((cmd_reg.op != mrws_pkg::CMD_FLUSH) || moved_reg);
    end

    always_comb
    begin
        dlv = mrws_pkg::simple_result(mrws_pkg::KIND_DELIVER, exp_reg);
        dlv.tag = tag_rd_reg;
        dlv.last = !follows && !present_reg[head_inc];
    end

    // First update stage: presence rotated to the ring head, and the lanes still behind
    // the sender's highest sequence (the expected sequence on a tick flush).
    always_comb
    begin
        dbl_rot = {present_reg, present_reg} >> head_reg;
        rot = dbl_rot[WINDOW-1:0];
        ref_max = (cmd_reg.op == mrws_pkg::CMD_FLUSH) ? exp_reg : cmd_reg.max_seq;
        dm = exp_reg - ref_max;
        for (int i = 0; i < WINDOW; i++)
        begin
            lane_sum[i] = dm + 16'(i);
            neg[i] = lane_sum[i][15];
        end
    end

    // Second stage: length of the in-order run.
    always_comb
    begin
        rot_inc = (WINDOW + 1)'(rot_reg) + (WINDOW + 1)'(1);
        run = rot_reg & ~rot_inc[WINDOW-1:0];
        first_zero = ~rot_reg & rot_inc[WINDOW-1:0];
        fz_idx = '0;
        for (int i = 0; i < WINDOW; i++)
        begin
            if (first_zero[i])
            begin
                fz_idx = fz_idx | CNT_W'(i);
            end
        end
        off = rot_inc[WINDOW] ? CNT_W'(WINDOW) : fz_idx;
    end

    // Third stage: the scan runs from the end of the run up to the first lane that is
    // not behind the sender.
    always_comb
    begin
        after = ~run_reg;
        brk = ~neg_reg & after;
        below = (brk - WINDOW'(1)) & ~brk;
        allowed = after & below;
    end

    // Last stage: bitmap, highest sequence and byte count.
    always_comb
    begin
        held_ext = EXT_W'(held_reg) >> off_reg;
        top_idx = '0;
        for (int i = 0; i < WINDOW; i++)
        begin
            if (held_reg[i])
            begin
                top_idx = IDX_W'(i);
            end
        end
        has_held = (held_reg != '0);
        one_ahead = !has_held && any_allowed_reg;
        hi_rel = CNT_W'(top_idx) + CNT_W'(1);
        span = has_held ? hi_rel - off_reg : CNT_W'(one_ahead);
        bsum = SUM_W'(span) + SUM_W'(mrws_pkg::BYTE_ROUND);
        bq = bsum >> 3;
        upd = '0;
        upd.kind = mrws_pkg::KIND_UPDATE;
        upd.seq = exp_reg + 16'(off_reg);
        upd.max_seq = has_held ? exp_reg + 16'(hi_rel) : upd.seq + 16'(one_ahead);
        upd.bitmap = held_ext[mrws_pkg::BM_W-1:0];
        upd.bytes = (bq > SUM_W'(mrws_pkg::MAX_BYTES)) ? 3'(mrws_pkg::MAX_BYTES) : bq[2:0];
        upd.tick = (cmd_reg.op == mrws_pkg::CMD_FLUSH) ? 32'd0 : cmd_reg.tick;
        upd.last = 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (store)
        begin
            tag_mem[slot] <= q_cmd.payload_tag;
        end
        tag_rd_reg <= tag_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            link_reg <= LINK_IDLE;
            exp_reg <= '0;
            head_reg <= '0;
            present_reg <= '0;
            cmd_reg <= '0;
            moved_reg <= 1'b0;
            rot_reg <= '0;
            neg_reg <= '0;
            run_reg <= '0;
            off_reg <= '0;
            held_reg <= '0;
            any_allowed_reg <= 1'b0;
            res_valid_reg <= 1'b0;
            res_reg <= '0;
        end
        else
        begin
            res_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (q_valid)
                    begin
                        cmd_reg <= q_cmd;
                        moved_reg <= 1'b0;
                        unique case (q_cmd.op)
                            mrws_pkg::CMD_JOIN:
                            begin
                                if ((link_reg == LINK_IDLE) || (link_reg == LINK_JOIN))
                                begin
                                    res_valid_reg <= 1'b1;
                                    if (q_cmd.retries_zero)
                                    begin
                                        link_reg <= LINK_IDLE;
                                        res_reg <= mrws_pkg::simple_result(
                                            mrws_pkg::KIND_JOIN_FAILED, 16'd0);
                                    end
                                    else
                                    begin
                                        link_reg <= LINK_JOIN;
                                        res_reg <= mrws_pkg::simple_result(
                                            mrws_pkg::KIND_JOIN_REQ, 16'd0);
                                    end
                                end
                            end
                            mrws_pkg::CMD_JOIN_RESP:
                            begin
                                if (((link_reg == LINK_JOIN) || (link_reg == LINK_DATA))
                                    && (q_cmd.response_id == client_id))
                                begin
                                    link_reg <= LINK_DATA;
                                    exp_reg <= q_cmd.seq;
                                    res_valid_reg <= 1'b1;
                                    res_reg <= mrws_pkg::simple_result(
                                        mrws_pkg::KIND_JOIN_ECHO, q_cmd.seq);
                                end
                            end
                            mrws_pkg::CMD_DATA:
                            begin
                                if (link_reg == LINK_DATA)
                                begin
                                    if (in_win)
                                    begin
                                        present_reg[slot] <= 1'b1;
                                        state_reg <= ST_PREP;
                                    end
                                    else if (q_cmd.wants_update)
                                    begin
                                        state_reg <= ST_SCAN;
                                    end
                                end
                            end
                            mrws_pkg::CMD_KEEPALIVE:
                            begin
                                if (link_reg == LINK_DATA)
                                begin
                                    state_reg <= ST_FLUSH;
                                end
                            end
                            mrws_pkg::CMD_FLUSH:
                            begin
                                state_reg <= ST_FLUSH;
                            end
                            mrws_pkg::CMD_LEAVE_REQ:
                            begin
                                if ((link_reg == LINK_DATA) || (link_reg == LINK_LEAVE))
                                begin
                                    link_reg <= LINK_LEAVE;
                                    res_valid_reg <= 1'b1;
                                    res_reg <= mrws_pkg::simple_result(
                                        mrws_pkg::KIND_LEAVE_REQ, 16'd0);
                                end
                            end
                            mrws_pkg::CMD_LEAVE_RESP:
                            begin
                                if ((link_reg == LINK_LEAVE) || (link_reg == LINK_IDLE))
                                begin
                                    link_reg <= LINK_IDLE;
                                    res_valid_reg <= 1'b1;
                                    res_reg <= mrws_pkg::simple_result(
                                        mrws_pkg::KIND_LEFT, 16'd0);
                                end
                            end
                            default:
                            begin
                                state_reg <= ST_IDLE;
                            end
                        endcase
                    end
                end
                ST_PREP:
                begin
                    state_reg <= ST_FLUSH;
                end
                ST_FLUSH:
                begin
                    if (deliver)
                    begin
                        res_valid_reg <= 1'b1;
                        res_reg <= dlv;
                        present_reg[head_reg] <= 1'b0;
                        head_reg <= head_inc;
                        exp_reg <= exp_reg + 16'd1;
                        moved_reg <= 1'b1;
                    end
                    else
                    begin
                        state_reg <= upd_at_end ? ST_SCAN : ST_IDLE;
                    end
                end
                ST_SCAN:
                begin
                    rot_reg <= rot;
                    neg_reg <= neg;
                    state_reg <= ST_RUN;
                end
                ST_RUN:
                begin
                    run_reg <= run;
                    off_reg <= off;
                    state_reg <= ST_MASK;
                end
                ST_MASK:
                begin
                    held_reg <= rot_reg & allowed;
                    any_allowed_reg <= (allowed != '0);
                    state_reg <= ST_REPORT;
                end
                ST_REPORT:
                begin
                    res_valid_reg <= 1'b1;
                    res_reg <= upd;
                    state_reg <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule
